@@ src/dcf_pkg.sv @@
// Shared types and constants of the deduplicating counting queue.
`default_nettype none

package dcf_pkg;

    localparam int ACT_BITS = 2;
    localparam int POS_BITS = 4;
    localparam int ST_BITS  = 2;

    localparam logic [ACT_BITS-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_PEEK   = 2'd2;
    localparam logic [ACT_BITS-1:0] ACT_NONE   = 2'd3;

    localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [ST_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_BITS-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_BITS-1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ src/dcf_if.sv @@
// Request and response channel interfaces of the deduplicating counting queue.
`default_nettype none

interface dcf_req_if #(
    parameter int KEY_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic [dcf_pkg::ACT_BITS-1:0] action;
    logic [KEY_BITS-1:0]          key;
    logic [dcf_pkg::POS_BITS-1:0] position;

    modport source (output valid, action, key, position, input ready);
    modport sink   (input valid, action, key, position, output ready);
endinterface

interface dcf_rsp_if #(
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16,
    parameter int OCC_BITS   = 5
);
    logic                        valid;
    logic                        ready;
    logic [KEY_BITS-1:0]         out_key;
    logic [COUNT_BITS-1:0]       out_count;
    logic [OCC_BITS-1:0]         occupancy;
    logic [dcf_pkg::ST_BITS-1:0] status;
    logic                        was_new;

    modport source (output valid, out_key, out_count, occupancy, status, was_new, input ready);
    modport sink   (input valid, out_key, out_count, occupancy, status, was_new, output ready);
endinterface

`default_nettype wire

@@ src/dcf_store.sv @@
// Key and count memories with one write port and one registered read port.
`default_nettype none

module dcf_store #(
    parameter int DEPTH      = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16,
    parameter int SLOT_BITS  = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [SLOT_BITS-1:0]  i_wr_addr,
    input  wire logic [KEY_BITS-1:0]   i_wr_key,
    input  wire logic [COUNT_BITS-1:0] i_wr_count,
    input  wire logic                  i_rd_en,
    input  wire logic [SLOT_BITS-1:0]  i_rd_addr,
    output logic      [KEY_BITS-1:0]   o_rd_key,
    output logic      [COUNT_BITS-1:0] o_rd_count
);

    logic [KEY_BITS-1:0]   r_key_mem   [DEPTH];
    logic [COUNT_BITS-1:0] r_count_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr]   <= i_wr_key;
            r_count_mem[i_wr_addr] <= i_wr_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_key   <= r_key_mem[i_rd_addr];
            o_rd_count <= r_count_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/dedup_counting_fifo.sv @@
// Deduplicating queue of keys with saturating occurrence counts per entry.
// An ignored action, an empty or range error, or an insert to an empty queue goes to S_EMIT.
// A remove or peek does one memory read in S_READ, then goes to the result stage S_EMIT.
// Other inserts scan in S_SCAN, reading one stored key a cycle until a match or the end.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset empties the queue; the memories are not cleared.
`default_nettype none

module dedup_counting_fifo #(
    parameter int DEPTH      = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dcf_req_if.sink   i_req,
    dcf_rsp_if.source o_rsp
);

    import dcf_pkg::*;

    localparam int SLOT_BITS = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int OCC_BITS  = $clog2(DEPTH + 1);
    localparam int SUM_BITS  = ((SLOT_BITS > POS_BITS) ? SLOT_BITS : POS_BITS) + 1;

    t_state                r_state, n_state;
    logic [SLOT_BITS-1:0]  r_head, n_head;
    logic [OCC_BITS-1:0]   r_occ, n_occ;
    logic [OCC_BITS-1:0]   r_idx, n_idx;
    logic [SLOT_BITS-1:0]  r_slot, n_slot;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic                  r_is_remove, n_is_remove;

    logic [KEY_BITS-1:0]   r_res_key, n_res_key;
    logic [COUNT_BITS-1:0] r_res_count, n_res_count;
    logic [ST_BITS-1:0]    r_res_status, n_res_status;
    logic                  r_res_new, n_res_new;

    logic                  r_out_valid, n_out_valid;
    logic [KEY_BITS-1:0]   r_out_key, n_out_key;
    logic [COUNT_BITS-1:0] r_out_count, n_out_count;
    logic [OCC_BITS-1:0]   r_out_occ, n_out_occ;
    logic [ST_BITS-1:0]    r_out_status, n_out_status;
    logic                  r_out_new, n_out_new;

    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [COUNT_BITS-1:0] wr_count;
    logic                  rd_en;
    logic [SLOT_BITS-1:0]  rd_addr;
    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_count;

    logic                  in_ready;
    logic                  out_free;
    logic [SUM_BITS-1:0]   peek_sum;
    logic [SUM_BITS-1:0]   tail_sum;
    logic [SLOT_BITS-1:0]  peek_slot;
    logic [SLOT_BITS-1:0]  tail_slot;
    logic [SLOT_BITS-1:0]  slot_next;
    logic [SLOT_BITS-1:0]  head_next;
    logic [COUNT_BITS-1:0] count_inc;

    dcf_store #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS),
        .SLOT_BITS  (SLOT_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_key   (wr_key),
        .i_wr_count (wr_count),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rd_key),
        .o_rd_count (rd_count)
    );

    always_comb begin
        peek_sum = SUM_BITS'(r_head) + SUM_BITS'(i_req.position);
        if (peek_sum >= SUM_BITS'(DEPTH)) begin
            peek_sum = peek_sum - SUM_BITS'(DEPTH);
        end
        tail_sum = SUM_BITS'(r_head) + SUM_BITS'(r_occ);
        if (tail_sum >= SUM_BITS'(DEPTH)) begin
            tail_sum = tail_sum - SUM_BITS'(DEPTH);
        end
    end

    assign peek_slot = peek_sum[SLOT_BITS-1:0];
    assign tail_slot = tail_sum[SLOT_BITS-1:0];
    assign slot_next = (r_slot == SLOT_BITS'(DEPTH - 1)) ? '0 : r_slot + 1'b1;
    assign head_next = (r_head == SLOT_BITS'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign count_inc = (rd_count == {COUNT_BITS{1'b1}}) ? rd_count : rd_count + 1'b1;
    assign out_free  = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_slot       = r_slot;
        n_key        = r_key;
        n_is_remove  = r_is_remove;
        n_res_key    = r_res_key;
        n_res_count  = r_res_count;
        n_res_status = r_res_status;
        n_res_new    = r_res_new;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_key    = r_out_key;
        n_out_count  = r_out_count;
        n_out_occ    = r_out_occ;
        n_out_status = r_out_status;
        n_out_new    = r_out_new;
        in_ready     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_slot;
        wr_key       = r_key;
        wr_count     = COUNT_BITS'(1);
        rd_en        = 1'b0;
        rd_addr      = r_head;

        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_req.valid) begin
                    n_key        = i_req.key;
                    n_res_key    = '0;
                    n_res_count  = '0;
                    n_res_status = ST_OK;
                    n_res_new    = 1'b0;
                    n_state      = S_EMIT;
                    unique case (i_req.action)
                        ACT_INSERT: begin
                            if (r_occ == '0) begin
                                wr_en       = 1'b1;
                                wr_addr     = r_head;
                                wr_key      = i_req.key;
                                n_occ       = OCC_BITS'(1);
                                n_res_count = COUNT_BITS'(1);
                                n_res_new   = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_slot  = r_head;
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        ACT_REMOVE: begin
                            if (r_occ == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = r_head;
                                n_is_remove = 1'b1;
                                n_state     = S_READ;
                            end
                        end
                        ACT_PEEK: begin
                            if (r_occ == '0) begin
                                n_res_status = ST_EMPTY;
                            end else if (SUM_BITS'(i_req.position) >= SUM_BITS'(r_occ)) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = peek_slot;
                                n_is_remove = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        ACT_NONE: begin
                            n_res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_key   = rd_key;
                n_res_count = rd_count;
                if (r_is_remove) begin
                    n_head = head_next;
                    n_occ  = r_occ - 1'b1;
                end
                n_state = S_EMIT;
            end
            S_SCAN: begin
                priority if (rd_key == r_key) begin
                    wr_en       = 1'b1;
                    wr_addr     = r_slot;
                    wr_count    = count_inc;
                    n_res_count = count_inc;
                    n_state     = S_EMIT;
                end else if (r_idx + 1'b1 == r_occ) begin
                    if (r_occ == OCC_BITS'(DEPTH)) begin
                        n_res_status = ST_FULL;
                    end else begin
                        wr_en       = 1'b1;
                        wr_addr     = tail_slot;
                        n_occ       = r_occ + 1'b1;
                        n_res_count = COUNT_BITS'(1);
                        n_res_new   = 1'b1;
                    end
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_slot  = slot_next;
                    rd_en   = 1'b1;
                    rd_addr = slot_next;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = r_res_key;
                    n_out_count  = r_res_count;
                    n_out_occ    = r_occ;
                    n_out_status = r_res_status;
                    n_out_new    = r_res_new;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_slot       <= n_slot;
        r_key        <= n_key;
        r_is_remove  <= n_is_remove;
        r_res_key    <= n_res_key;
        r_res_count  <= n_res_count;
        r_res_status <= n_res_status;
        r_res_new    <= n_res_new;
        r_out_key    <= n_out_key;
        r_out_count  <= n_out_count;
        r_out_occ    <= n_out_occ;
        r_out_status <= n_out_status;
        r_out_new    <= n_out_new;
    end

    assign i_req.ready     = in_ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.out_key   = r_out_key;
    assign o_rsp.out_count = r_out_count;
    assign o_rsp.occupancy = r_out_occ;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.was_new   = r_out_new;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_BITS'(DEPTH))
        else $error("Occupancy exceeds the queue depth.");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_occ))
        else $error("Scan index runs past the stored entries.");

    a_write_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_state == S_EMIT))
        else $error("A memory write did not finish the item.");

    a_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_new) |->
            (r_out_status == ST_OK && r_out_count == COUNT_BITS'(1) && r_out_occ != '0))
        else $error("A new entry result carries inconsistent fields.");

    a_first_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && in_ready && i_req.action == ACT_INSERT && r_occ == '0)
            |=> (r_occ == OCC_BITS'(1)))
        else $error("Insert into an empty queue did not append.");

endmodule

`default_nettype wire

@@ test/dcf_checker.sv @@
// Checker that predicts every response of the deduplicating counting queue and compares it.
`default_nettype none

module dcf_checker #(
    parameter int DEPTH      = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16,
    parameter int OCC_BITS   = 5
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dcf_req_if        i_req,
    dcf_rsp_if        i_rsp,
    output int        o_errors,
    output int        o_pending,
    output int        o_responses
);
    timeunit 1ns;
    timeprecision 1ps;

    import dcf_pkg::*;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
        logic [OCC_BITS-1:0]   occupancy;
        logic [ST_BITS-1:0]    status;
        logic                  was_new;
    } t_response;

    logic [KEY_BITS-1:0]   key_slots   [DEPTH];
    logic [COUNT_BITS-1:0] count_slots [DEPTH];
    int                    head_index = 0;
    int                    held       = 0;
    t_response             expected_responses [$];

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_responses = 0;
    end

    function automatic t_response queue_step(input logic [ACT_BITS-1:0] act,
                                             input logic [KEY_BITS-1:0] key,
                                             input logic [POS_BITS-1:0] pos);
        t_response r;
        bit        hit;
        int        slot;
        r   = '0;
        hit = 1'b0;
        if (act == ACT_INSERT) begin
            for (int i = 0; i < held; i++) begin
                slot = (head_index + i) % DEPTH;
                if (!hit && key_slots[slot] == key) begin
                    if (count_slots[slot] != '1) begin
                        count_slots[slot] = count_slots[slot] + 1'b1;
                    end
                    r.count = count_slots[slot];
                    hit     = 1'b1;
                end
            end
            if (!hit) begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot              = (head_index + held) % DEPTH;
                    key_slots[slot]   = key;
                    count_slots[slot] = COUNT_BITS'(1);
                    held++;
                    r.count   = COUNT_BITS'(1);
                    r.was_new = 1'b1;
                end
            end
        end else if (act == ACT_REMOVE) begin
            if (held == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.key      = key_slots[head_index];
                r.count    = count_slots[head_index];
                head_index = (head_index + 1) % DEPTH;
                held--;
            end
        end else if (act == ACT_PEEK) begin
            if (held == 0) begin
                r.status = ST_EMPTY;
            end else if (int'(pos) >= held) begin
                r.status = ST_RANGE;
            end else begin
                slot    = (head_index + int'(pos)) % DEPTH;
                r.key   = key_slots[slot];
                r.count = count_slots[slot];
            end
        end
        r.occupancy = held[OCC_BITS-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_response want;
        if (!i_rst_n) begin
            head_index = 0;
            held       = 0;
            expected_responses.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                o_responses++;
                if (expected_responses.size() == 0) begin
                    $display("%0t: response with no item outstanding, actual key %0h count %0h",
                             $time, i_rsp.out_key, i_rsp.out_count);
                    o_errors++;
                end else begin
                    want = expected_responses.pop_front();
                    compare_field("out_key", want.key, i_rsp.out_key);
                    compare_field("out_count", want.count, i_rsp.out_count);
                    compare_field("occupancy", want.occupancy, i_rsp.occupancy);
                    compare_field("status", want.status, i_rsp.status);
                    compare_field("was_new", want.was_new, i_rsp.was_new);
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_responses.push_back(queue_step(i_req.action, i_req.key,
                                                        i_req.position));
            end
        end
        o_pending <= expected_responses.size();
    end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Top of the testbench: clock, reset, stimulus, receiver stalls and the final verdict.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dcf_pkg::*;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 32;
    localparam int COUNT_BITS   = 16;
    localparam int RANDOM_ITEMS = 620;
    localparam int HOLDOFF      = 300;
    localparam int LIMIT        = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   responses;
    int   items_sent = 0;
    int   cycles     = 0;
    bit   want_holdoff = 1'b0;
    bit   req_steady = 1'b0;
    bit   rsp_steady = 1'b0;

    dcf_req_if #(.KEY_BITS(KEY_BITS)) req_ch ();
    dcf_rsp_if #(.KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)) rsp_ch ();

    dedup_counting_fifo #(
        .DEPTH(DEPTH),
        .KEY_BITS(KEY_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch),
        .o_rsp(rsp_ch)
    );

    dcf_checker #(
        .DEPTH(DEPTH),
        .KEY_BITS(KEY_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch),
        .i_rsp(rsp_ch),
        .o_errors(errors),
        .o_pending(pending),
        .o_responses(responses)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Timed out after %0d cycles with %0d responses outstanding.",
                     cycles, pending);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic offer_item(input logic [ACT_BITS-1:0] act, input logic [KEY_BITS-1:0] key,
                              input logic [POS_BITS-1:0] pos);
        int gap;
        gap = req_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.key      <= key;
        req_ch.position <= pos;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
        if ($urandom_range(0, 39) == 0) begin
            req_steady = !req_steady;
        end
    endtask

    initial begin : receiver
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (want_holdoff) begin
                stall        = HOLDOFF;
                want_holdoff = 1'b0;
            end else begin
                stall = rsp_steady ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            if ($urandom_range(0, 39) == 0) begin
                rsp_steady = !rsp_steady;
            end
        end
    end

    initial begin : stimulus
        logic [KEY_BITS-1:0] key_pool [20];
        logic [KEY_BITS-1:0] key;
        logic [ACT_BITS-1:0] act;
        int                  fill_bias;
        int                  insert_pct;
        int                  pick;

        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.action   <= ACT_NONE;
        req_ch.key      <= '0;
        req_ch.position <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_item(ACT_REMOVE, $urandom, 4'd0);
        offer_item(ACT_PEEK, $urandom, 4'd0);
        offer_item(ACT_NONE, $urandom, 4'd7);
        offer_item(ACT_INSERT, '0, 4'd0);
        offer_item(ACT_INSERT, '1, 4'd0);
        offer_item(ACT_INSERT, '0, 4'd0);
        offer_item(ACT_PEEK, '0, 4'd0);
        offer_item(ACT_PEEK, '0, 4'd1);
        offer_item(ACT_PEEK, '0, 4'd15);
        offer_item(ACT_NONE, '1, 4'd15);
        offer_item(ACT_REMOVE, '0, 4'd0);
        for (int i = 0; i < DEPTH - 1; i++) begin
            offer_item(ACT_INSERT, 32'h1000_0000 + i * 32'h0111_1111, 4'd0);
        end
        offer_item(ACT_INSERT, 32'hA5A5_5A5A, 4'd0);
        offer_item(ACT_INSERT, '1, 4'd0);
        offer_item(ACT_PEEK, '0, 4'd15);
        offer_item(ACT_PEEK, '0, 4'd0);
        offer_item(ACT_REMOVE, '0, 4'd0);

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 20; i++) begin
            key_pool[i] = $urandom;
        end
        fill_bias = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                fill_bias = $urandom_range(0, 2);
            end
            if (n == 120 || n == 430) begin
                want_holdoff = 1'b1;
            end
            insert_pct = (fill_bias == 2) ? 75 : (fill_bias == 1) ? 50 : 25;
            pick       = $urandom_range(0, 99);
            if (pick < insert_pct) begin
                act = ACT_INSERT;
            end else if (pick < insert_pct + (100 - insert_pct) / 2) begin
                act = ACT_REMOVE;
            end else if (pick < 96) begin
                act = ACT_PEEK;
            end else begin
                act = ACT_NONE;
            end
            key = ($urandom_range(0, 3) == 0) ? KEY_BITS'($urandom)
                                                : key_pool[$urandom_range(0, 19)];
            offer_item(act, key, 4'($urandom_range(0, 15)));
        end
        req_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (2 * DEPTH + 8) @(posedge i_clk);

        $display("Sent %0d items: directed corner cases and %0d random ones.",
                 items_sent, RANDOM_ITEMS);
        $display("Checked %0d responses under random idling and long receiver hold-offs.",
                 responses);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ dedup_counting_fifo.f @@
src/dcf_pkg.sv
src/dcf_if.sv
src/dcf_store.sv
src/dedup_counting_fifo.sv
test/dcf_checker.sv
test/testbench.sv
